FILE: rtl/rlmbt_pkg.sv
package rlmbt_pkg;

  localparam int MAX_FRAME_WIDTH_DEF = 512;
  localparam int ROW_COORD_BITS_DEF  = 12;
  localparam int WORD_BITS           = 64;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_INNER_MODE  = 1'b0,
    CFG_FRAME_WIDTH = 1'b1
  } cfg_idx_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_SHIFT,
    ST_RENDER,
    ST_FLUSH
  } back_state_t;

  // bits of the global inclusive range s..e that fall in the word starting at lo
  function automatic logic [WORD_BITS-1:0] span_bits(input logic [31:0] lo,
                                                     input logic [31:0] s,
                                                     input logic [31:0] e);
    logic [WORD_BITS-1:0] m_hi;
    logic [WORD_BITS-1:0] m_lo;
    if (s > e || e < lo || s > lo + 32'd63) begin
      return '0;
    end
    m_hi = (e >= lo + 32'd63) ? '1 : ({WORD_BITS{1'b1}} >> 6'(lo + 32'd63 - e));
    m_lo = (s <= lo) ? '1 : ({WORD_BITS{1'b1}} << 6'(s - lo));
    return m_hi & m_lo;
  endfunction

endpackage

FILE: rtl/rlm_run_if.sv
interface rlm_run_if #(
  parameter int XW = 9,
  parameter int RW = 12
);
  logic          valid;
  logic          ready;
  logic [RW-1:0] run_row;
  logic [XW-1:0] run_left_x;
  logic [XW-1:0] run_right_x;
  logic          last_run;

  modport source(output valid, output run_row, output run_left_x, output run_right_x,
                 output last_run, input ready);
  modport sink(input valid, input run_row, input run_left_x, input run_right_x,
               input last_run, output ready);
endinterface

FILE: rtl/rlm_bnd_if.sv
interface rlm_bnd_if #(
  parameter int RW  = 12,
  parameter int FWW = 10
);
  logic                 valid;
  logic                 ready;
  logic signed [RW+1:0] out_row;
  logic signed [FWW-1:0] word_base_x;
  logic [63:0]          boundary_mask;
  logic                 end_of_region;

  modport source(output valid, output out_row, output word_base_x, output boundary_mask,
                 output end_of_region, input ready);
  modport sink(input valid, input out_row, input word_base_x, input boundary_mask,
               input end_of_region, output ready);
endinterface

FILE: rtl/rlm_cfg_if.sv
interface rlm_cfg_if #(
  parameter int DW = 10
);
  logic          valid;
  logic          ready;
  logic [0:0]    index;
  logic [DW-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/run_length_mask_boundary_tracer_core.sv
// Run-length mask boundary tracer.
// run (sink): one interval per beat, rows non-decreasing; last_run closes the region.
// bnd (source): 64-bit boundary words with their row and the column of bit 0;
//   end_of_region marks the final beat of a region (an empty word if none was found).
// cfg (sink): register writes, index 0 = inner_mode, 1 = pixel width; always ready.
//   Write only while the block is idle.
// Flow: a beat passes a two-entry queue into the back-end sequencer. An interval
//   on the current row passes the take, render and flush steps. Each closed row
//   steps through one word of the three rotating row stores per cycle unless the
//   output stalls, then does a row shift; an advance closes up to 3 rows and
//   last_run closes 3. A found word is held until the next word is found or the beat's flush.
// Reset (rst, synchronous) empties the queue and output register, closes any open
//   region and restores inner_mode = 1 and the pixel width to MAX_FRAME_WIDTH.
// A stalled receiver holds the output register; the sequencer stops at the next
//   word that needs to go out, and the queue then fills and drops run.ready.
module run_length_mask_boundary_tracer_core #(
  parameter int MAX_FRAME_WIDTH = rlmbt_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int ROW_COORD_BITS  = rlmbt_pkg::ROW_COORD_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  rlm_run_if.sink run,
  rlm_bnd_if.source bnd,
  rlm_cfg_if.sink cfg
);
  import rlmbt_pkg::*;

  localparam int XW  = $clog2(MAX_FRAME_WIDTH);
  localparam int FWW = XW + 1;
  localparam int NW  = (MAX_FRAME_WIDTH + 2 + WORD_BITS - 1) / WORD_BITS;
  localparam int RW  = ROW_COORD_BITS;

  logic           inner_mode;
  logic [FWW-1:0] pix_width;
  logic [FWW-1:0] fw_eff;

  logic           q_valid;
  logic           q_ready;
  logic [RW-1:0]  q_row;
  logic [FWW-1:0] q_s;
  logic [FWW-1:0] q_e;
  logic           q_has;
  logic           q_last;

  assign cfg.ready = 1'b1;

  // take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_mode <= 1'b1;
      pix_width  <= FWW'(MAX_FRAME_WIDTH);
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_INNER_MODE:  inner_mode <= cfg.data[0];
        CFG_FRAME_WIDTH: pix_width  <= cfg.data;
        default: ;
      endcase
    end
  end

  // saturate width to the store size
  assign fw_eff = (pix_width > FWW'(MAX_FRAME_WIDTH)) ? FWW'(MAX_FRAME_WIDTH) : pix_width;

  rlmbt_front #(
    .XW (XW),
    .RW (RW),
    .FWW(FWW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .fw     (fw_eff),
    .run    (run),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_row  (q_row),
    .q_s    (q_s),
    .q_e    (q_e),
    .q_has  (q_has),
    .q_last (q_last)
  );

  rlmbt_back #(
    .NW (NW),
    .RW (RW),
    .FWW(FWW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .inner_mode(inner_mode),
    .fw        (fw_eff),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_row     (q_row),
    .q_s       (q_s),
    .q_e       (q_e),
    .q_has     (q_has),
    .q_last    (q_last),
    .bnd       (bnd)
  );

endmodule

FILE: rtl/rlmbt_front.sv
module rlmbt_front #(
  parameter int XW  = 9,
  parameter int RW  = 12,
  parameter int FWW = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [FWW-1:0] fw,
  rlm_run_if.sink        run,
  output logic           q_valid,
  input  logic           q_ready,
  output logic [RW-1:0]  q_row,
  output logic [FWW-1:0] q_s,
  output logic [FWW-1:0] q_e,
  output logic           q_has,
  output logic           q_last
);
  import rlmbt_pkg::*;

  logic [RW-1:0]  ent_row  [2];
  logic [FWW-1:0] ent_s    [2];
  logic [FWW-1:0] ent_e    [2];
  logic           ent_has  [2];
  logic           ent_last [2];
  logic           wp;
  logic           rp;
  logic [1:0]     count;

  logic [FWW-1:0] lx;
  logic [FWW-1:0] rx;
  logic [FWW-1:0] hi;
  logic           has;
  logic           push;
  logic           pop;

  // clip the interval to the frame
  always_comb begin
    lx  = FWW'(run.run_left_x);
    rx  = FWW'(run.run_right_x);
    hi  = (fw == '0) ? '0 : ((rx < fw - 1'b1) ? rx : fw - 1'b1);
    has = (fw != '0) && (lx < fw) && (lx <= hi);
  end

  assign run.ready = (count != 2'd2);
  assign push      = run.valid && run.ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_row     = ent_row[rp];
  assign q_s       = ent_s[rp];
  assign q_e       = ent_e[rp];
  assign q_has     = ent_has[rp];
  assign q_last    = ent_last[rp];

  // hold classified beats until the back end takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        ent_row[wp]  <= run.run_row;
        ent_s[wp]    <= lx + 1'b1;
        ent_e[wp]    <= hi + 1'b1;
        ent_has[wp]  <= has;
        ent_last[wp] <= run.last_run;
        wp           <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1) else $error("queue count lost a beat");
`endif

endmodule

FILE: rtl/rlmbt_back.sv
module rlmbt_back #(
  parameter int NW  = 9,
  parameter int RW  = 12,
  parameter int FWW = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           inner_mode,
  input  logic [FWW-1:0] fw,
  input  logic           q_valid,
  output logic           q_ready,
  input  logic [RW-1:0]  q_row,
  input  logic [FWW-1:0] q_s,
  input  logic [FWW-1:0] q_e,
  input  logic           q_has,
  input  logic           q_last,
  rlm_bnd_if.source      bnd
);
  import rlmbt_pkg::*;

  localparam int KW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int NXT = (NW > 1) ? 1 : 0;
  localparam int YW  = RW + 2;

  back_state_t state, state_next;

  logic [63:0] above   [NW];
  logic [63:0] middle  [NW];
  logic [63:0] loading [NW];

  logic [RW-1:0]  ly;
  logic [RW:0]    fin;
  logic           open;
  logic [RW-1:0]  c_row;
  logic [FWW-1:0] c_s;
  logic [FWW-1:0] c_e;
  logic           c_has;
  logic           c_last;
  logic           closing_last;
  logic [1:0]     rows_left;
  logic [YW-1:0]  y;
  logic [KW-1:0]  k;
  logic [63:0]    prev;

  logic            pend_valid;
  logic [YW-1:0]   pend_row;
  logic [FWW-1:0]  pend_base;
  logic [63:0]     pend_mask;
  logic            out_valid;

  logic [63:0]   fm0, fm1, a, m, b, mn, left, right, w;
  logic          w_nz, push_ok, stall, adv, last_word, need_push, flush_done, load_out;
  logic [RW-1:0] steps;
  logic [1:0]    cnt;

  // boundary word at the head of the rotating stores
  always_comb begin
    fm0   = span_bits(32'(k) << 6, 32'd1, 32'(fw));
    fm1   = span_bits((32'(k) + 32'd1) << 6, 32'd1, 32'(fw));
    a     = above[0] & fm0;
    m     = middle[0] & fm0;
    b     = loading[0] & fm0;
    mn    = (32'(k) + 32'd1 < 32'(NW)) ? (middle[NXT] & fm1) : '0;
    left  = (m << 1) | (prev >> 63);
    right = (m >> 1) | (mn << 63);
    w     = inner_mode ? (m & ~(left & right & a & b)) : (~m & (left | right | a | b));
    w_nz  = (w != '0);
  end

  always_comb begin
    push_ok    = !out_valid || bnd.ready;
    stall      = w_nz && pend_valid && !push_ok;
    adv        = !stall;
    last_word  = (32'(k) == 32'(NW - 1));
    need_push  = pend_valid || c_last;
    flush_done = !need_push || push_ok;
    load_out   = ((state == ST_CLOSE) && adv && w_nz && pend_valid) ||
                 ((state == ST_FLUSH) && flush_done && need_push);
    steps      = q_row - ly;
    cnt        = (steps >= RW'(3)) ? 2'd3 : steps[1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (open && q_row > ly) ? ST_CLOSE : ST_RENDER;
        end
      end
      ST_CLOSE: begin
        if (adv && last_word) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (rows_left == 2'd1) begin
          state_next = closing_last ? ST_FLUSH : ST_RENDER;
        end else begin
          state_next = ST_CLOSE;
        end
      end
      ST_RENDER: state_next = c_last ? ST_CLOSE : ST_FLUSH;
      ST_FLUSH: begin
        if (flush_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready = (state == ST_IDLE);
  end

  assign bnd.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and stores
  always_ff @(posedge clk) begin
    if (rst) begin
      open       <= 1'b0;
      ly         <= '0;
      fin        <= '0;
      k          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && bnd.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            c_row        <= q_row;
            c_s          <= q_s;
            c_e          <= q_e;
            c_has        <= q_has;
            c_last       <= q_last;
            closing_last <= 1'b0;
            k            <= '0;
            prev         <= '0;
            y            <= YW'(ly) - 1'b1;
            rows_left    <= cnt;
            if (!open) begin
              for (int i = 0; i < NW; i++) begin
                above[i]   <= '0;
                middle[i]  <= '0;
                loading[i] <= '0;
              end
              ly   <= q_row;
              fin  <= (RW+1)'(q_row);
              open <= 1'b1;
            end
          end
        end
        ST_CLOSE: begin
          if (adv) begin
            if (w_nz) begin
              if (pend_valid) begin
                out_valid         <= 1'b1;
                bnd.out_row       <= pend_row;
                bnd.word_base_x   <= pend_base;
                bnd.boundary_mask <= pend_mask;
                bnd.end_of_region <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_row   <= y;
              pend_base  <= FWW'((32'(k) << 6) - 32'd1);
              pend_mask  <= w;
            end
            // rotate one word toward the head
            for (int i = 0; i < NW; i++) begin
              above[i]   <= above[(i + 1) % NW];
              middle[i]  <= middle[(i + 1) % NW];
              loading[i] <= loading[(i + 1) % NW];
            end
            prev <= m;
            k    <= last_word ? '0 : k + 1'b1;
          end
        end
        ST_SHIFT: begin
          for (int i = 0; i < NW; i++) begin
            above[i]   <= middle[i];
            middle[i]  <= loading[i];
            loading[i] <= '0;
          end
          fin       <= (RW+1)'(y + 1'b1);
          y         <= y + 1'b1;
          rows_left <= rows_left - 1'b1;
          prev      <= '0;
          if (rows_left == 2'd1 && !closing_last) begin
            ly <= c_row;
          end
        end
        ST_RENDER: begin
          if (c_row == ly && c_has) begin
            for (int i = 0; i < NW; i++) begin
              loading[i] <= loading[i] | span_bits(32'(i) << 6, 32'(c_s), 32'(c_e));
            end
          end
          if (c_last) begin
            closing_last <= 1'b1;
            rows_left    <= 2'd3;
            y            <= YW'(ly) - 1'b1;
          end
        end
        ST_FLUSH: begin
          if (flush_done) begin
            if (need_push) begin
              out_valid         <= 1'b1;
              bnd.end_of_region <= c_last;
              if (pend_valid) begin
                bnd.out_row       <= pend_row;
                bnd.word_base_x   <= pend_base;
                bnd.boundary_mask <= pend_mask;
              end else begin
                bnd.out_row       <= YW'(fin) - 1'b1;
                bnd.word_base_x   <= '1;
                bnd.boundary_mask <= '0;
              end
            end
            pend_valid <= 1'b0;
            if (c_last) begin
              for (int i = 0; i < NW; i++) begin
                above[i]   <= '0;
                middle[i]  <= '0;
                loading[i] <= '0;
              end
              ly   <= '0;
              fin  <= '0;
              open <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rows_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLOSE |-> rows_left != 2'd0) else $error("close pass with no rows left");
  a_word_range: assert property (@(posedge clk) disable iff (rst)
    32'(k) < 32'(NW)) else $error("word counter out of range");
  a_region_closed: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH && flush_done && c_last |=> !open && !pend_valid)
    else $error("region left open after last beat");
  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH && flush_done && c_last |=> out_valid && bnd.end_of_region)
    else $error("end mark missing");
`endif

endmodule
